### hw/rtl/dbfd_pkg.sv
// Shared types, constants and the logistic lookup table of the day bar LED frame core.
package dbfd_pkg;

    // Frame geometry
    localparam int LED_COUNT       = 112;
    localparam int HALF_BYTES      = 14;
    localparam int FRAME_BYTES     = 28;
    localparam int BYTE_IDX_W      = 5;
    localparam int HALF_IDX_W      = 4;
    localparam int LOST_MARK_IDX   = HALF_BYTES / 2;
    localparam int LOST_BAR_IDX    = HALF_BYTES + HALF_BYTES / 2;

    // Field widths
    localparam int FRAC_W  = 17;
    localparam int DUTY_W  = 10;
    localparam int LIMIT_W = 8;
    localparam int TAU_W   = 8;
    localparam int SIG_W   = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // LED position: round(LED_COUNT * frac), frac below 2.0
    localparam int POS_W   = $clog2(2 * LED_COUNT + 1);
    localparam int DPROD_W = FRAC_W + $clog2(LED_COUNT + 1) + 1;
    localparam int DIFF_W  = POS_W + 4;

    // Sigmoid lookup
    localparam int SIGMOID_ENTRIES = 512;
    localparam int SIG_IDX_W       = $clog2(SIGMOID_ENTRIES);
    localparam int ZSPAN           = 8;
    localparam int Q16_SHIFT       = 16;
    localparam int ZHALF           = ZSPAN * 65536;
    localparam int ZIDX_SHIFT      = 20;
    localparam int X_W             = FRAC_W + 1;
    localparam int Z_W             = X_W + TAU_W + 1;
    localparam int IDXP_W          = Z_W + SIG_IDX_W + 2;
    localparam int SERIES_TERMS    = 13;
    localparam longint Q16_ONE     = 64'sd65536;
    localparam longint Q30_ONE     = 64'sd1073741824;

    // Duty mixing
    localparam int SPAN_W = DUTY_W + 1;
    localparam int PROD_W = SPAN_W + SIG_W + 1;
    localparam int DSUM_W = PROD_W + 1;

    // Request queue between front and back
    localparam int CMD_FIFO_DEPTH = 2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_MIN_DUTY  = 2'd0;
    localparam logic [1:0] REG_FULL_DUTY = 2'd1;
    localparam logic [1:0] REG_LOSS_LIM  = 2'd2;
    localparam logic [1:0] REG_TAU_INV   = 2'd3;

    // Register reset values
    localparam logic [DUTY_W-1:0]  MIN_DUTY_RST  = 10'd100;
    localparam logic [DUTY_W-1:0]  FULL_DUTY_RST = 10'd1000;
    localparam logic [LIMIT_W-1:0] LOSS_LIM_RST  = 8'd30;
    localparam logic [TAU_W-1:0]   TAU_INV_RST   = 8'd72;

    typedef struct packed {
        logic              fix_ok;
        logic [FRAC_W-1:0] day_frac;
        logic [FRAC_W-1:0] sunset_frac;
        logic              no_sunset;
        logic              sun_up;
    } rpt_t;

    typedef struct packed {
        logic [7:0]            led_byte;
        logic [BYTE_IDX_W-1:0] byte_index;
        logic                  last;
        logic [DUTY_W-1:0]     duty;
    } led_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  min_duty;
        logic [DUTY_W-1:0]  full_duty;
        logic [LIMIT_W-1:0] fix_loss_limit;
        logic [TAU_W-1:0]   tau_inverse;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_NORMAL = 2'd0,
        CMD_NOSUN  = 2'd1,
        CMD_LOST   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [POS_W-1:0]  day_pos;
        logic [POS_W-1:0]  sunset_pos;
        logic [FRAC_W-1:0] day_frac;
        logic [FRAC_W-1:0] sunset_frac;
        logic              sun_up;
    } cmd_t;

    typedef logic [SIGMOID_ENTRIES-1:0][SIG_W-1:0] sig_rom_t;

    // Quotient of two non-negative values, shift and subtract
    function automatic longint sig_udiv(input longint num, input longint den);
        longint quo;
        longint rem;
        quo = 64'sd0;
        rem = 64'sd0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'sd1;
            end
        end
        return quo;
    endfunction

    // e^-f in Q30 for f in Q16, truncated series
    function automatic longint sig_exp_series(input longint f);
        longint term;
        longint sum;
        term = Q30_ONE;
        sum  = Q30_ONE;
        for (int k = 1; k <= SERIES_TERMS; k++)
        begin
            term = sig_udiv(term * f, longint'(k) * Q16_ONE);
            if ((k & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return (sum < 0) ? 64'sd0 : sum;
    endfunction

    // Logistic values over -ZSPAN..+ZSPAN, evaluated at elaboration
    function automatic sig_rom_t sig_build();
        sig_rom_t tbl;
        longint   z;
        longint   a;
        longint   n;
        longint   r;
        longint   e1;
        longint   den;
        longint   v;
        tbl = '0;
        e1  = sig_exp_series(Q16_ONE);
        for (int i = 0; i < SIGMOID_ENTRIES; i++)
        begin
            z = ((longint'(i) * 2 * ZSPAN * Q16_ONE) >>> SIG_IDX_W) - ZSPAN * Q16_ONE;
            a = (z < 0) ? -z : z;
            n = a >>> 16;
            r = sig_exp_series(a & 64'sd65535);
            for (longint k = 0; k < n; k++)
            begin
                r = (r * e1) >>> 30;
            end
            den = Q30_ONE + r;
            if (z >= 0)
                v = sig_udiv(Q30_ONE * Q16_ONE + (den >>> 1), den);
            else
                v = sig_udiv(r * Q16_ONE + (den >>> 1), den);
            if (v > 65535)
                v = 65535;
            tbl[i] = v[SIG_W-1:0];
        end
        return tbl;
    endfunction

    localparam sig_rom_t SIG_ROM = sig_build();

endpackage

### hw/rtl/day_bar_led_frame_and_dimming_core.sv
// Top level of the day bar LED frame and dimming core: register port and block wiring.
//
// Each accepted position report with a fix, or any report once the fix is lost, produces a
// 28-byte LED driver frame (bytes 0..13 sunset marker, 14..27 day bar), one byte per cycle
// on the led channel while led_ready allows, every byte carrying the frame's PWM duty. A report
// without a fix while the fix is not yet lost produces nothing. A report that makes a frame
// is parked in a two-entry request queue; the frame builder sends the bytes straight away when no
// sunset occurs or the fix is lost, and otherwise first makes three sigmoid lookups (states MUL,
// IDX, ROM, ACC each) through the single table port, duty blending (MIX, DUTY), then 28 bytes.
// The last byte of one frame waits in the output register while the next frame's duty is
// worked out. Registers (byte address 4*i): min_duty, full_duty, fix_loss_limit, tau_inverse.
module day_bar_led_frame_and_dimming_core
    import dbfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rpt_valid,
    output logic              rpt_ready,
    input  rpt_t              rpt,
    output logic              led_valid,
    input  logic              led_ready,
    output led_t              led,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;
    logic       push;
    cmd_t       push_cmd;
    logic       pop;
    cmd_t       head;
    logic       empty;
    logic       full;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MIN_DUTY:  cfg_next.min_duty       = pwdata[DUTY_W-1:0];
                REG_FULL_DUTY: cfg_next.full_duty      = pwdata[DUTY_W-1:0];
                REG_LOSS_LIM:  cfg_next.fix_loss_limit = pwdata[LIMIT_W-1:0];
                REG_TAU_INV:   cfg_next.tau_inverse    = pwdata[TAU_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_MIN_DUTY:  prdata = DATA_W'(cfg_reg.min_duty);
            REG_FULL_DUTY: prdata = DATA_W'(cfg_reg.full_duty);
            REG_LOSS_LIM:  prdata = DATA_W'(cfg_reg.fix_loss_limit);
            REG_TAU_INV:   prdata = DATA_W'(cfg_reg.tau_inverse);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_duty       <= MIN_DUTY_RST;
            cfg_reg.full_duty      <= FULL_DUTY_RST;
            cfg_reg.fix_loss_limit <= LOSS_LIM_RST;
            cfg_reg.tau_inverse    <= TAU_INV_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dbfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt       (rpt),
        .cfg       (cfg_reg),
        .fifo_full (full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    dbfd_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    dbfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .led_valid (led_valid),
        .led_ready (led_ready),
        .led       (led)
    );

endmodule

### hw/rtl/dbfd_front.sv
// Front end: accepts position reports, tracks fix loss and classifies each report.
module dbfd_front
    import dbfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic rpt_valid,
    output logic rpt_ready,
    input  rpt_t rpt,
    input  cfg_t cfg,
    input  logic fifo_full,
    output logic push,
    output cmd_t push_cmd
);

    logic [LIMIT_W-1:0] missed_reg;
    logic [LIMIT_W-1:0] missed_next;
    logic               fix_lost_reg;
    logic               fix_lost_next;
    logic               accept;
    logic [LIMIT_W-1:0] missed_inc;
    logic [DPROD_W-1:0] day_prod;
    logic [DPROD_W-1:0] sun_prod;

    assign rpt_ready = !fifo_full;
    assign accept    = rpt_valid && rpt_ready;

    // Saturating miss count
    assign missed_inc = (missed_reg == '1) ? missed_reg : missed_reg + 1'b1;

    // LED positions, rounded half up
    assign day_prod = DPROD_W'(LED_COUNT) * DPROD_W'(rpt.day_frac)
                    + DPROD_W'(1 << (Q16_SHIFT - 1));
    assign sun_prod = DPROD_W'(LED_COUNT) * DPROD_W'(rpt.sunset_frac)
                    + DPROD_W'(1 << (Q16_SHIFT - 1));

    // Fix tracking and request classification
    always_comb
    begin
        missed_next   = missed_reg;
        fix_lost_next = fix_lost_reg;
        push          = 1'b0;
        push_cmd.kind        = CMD_LOST;
        push_cmd.day_pos     = day_prod[Q16_SHIFT +: POS_W];
        push_cmd.sunset_pos  = sun_prod[Q16_SHIFT +: POS_W];
        push_cmd.day_frac    = rpt.day_frac;
        push_cmd.sunset_frac = rpt.sunset_frac;
        push_cmd.sun_up      = rpt.sun_up;
        if (accept)
        begin
            if (rpt.fix_ok)
            begin
                missed_next   = '0;
                fix_lost_next = 1'b0;
                push          = 1'b1;
                push_cmd.kind = rpt.no_sunset ? CMD_NOSUN : CMD_NORMAL;
            end
            else
            begin
                missed_next   = missed_inc;
                fix_lost_next = fix_lost_reg || (missed_inc >= cfg.fix_loss_limit);
                push          = fix_lost_next;
                push_cmd.kind = CMD_LOST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            missed_reg   <= '0;
            fix_lost_reg <= 1'b1;
        end
        else
        begin
            missed_reg   <= missed_next;
            fix_lost_reg <= fix_lost_next;
        end
    end

endmodule

### hw/rtl/dbfd_cmd_fifo.sv
// Short request queue between the front end and the frame builder.
module dbfd_cmd_fifo
    import dbfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t             mem_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(CMD_FIFO_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    // The front end never writes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("request queue overflow");

endmodule

### hw/rtl/dbfd_back.sv
// Frame builder: sets the frame duty, via the sigmoid table on sunset days, and streams the 28 bytes.
module dbfd_back
    import dbfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  cmd_t head,
    input  logic empty,
    output logic pop,
    output logic led_valid,
    input  logic led_ready,
    output led_t led
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_IDX  = 8'b0000_0100,
        ST_ROM  = 8'b0000_1000,
        ST_ACC  = 8'b0001_0000,
        ST_MIX  = 8'b0010_0000,
        ST_DUTY = 8'b0100_0000,
        ST_SEND = 8'b1000_0000
    } back_state_t;

    localparam logic [1:0] LK_FIRST = 2'd0;
    localparam logic [1:0] LK_MID   = 2'd1;
    localparam logic [1:0] LK_LAST  = 2'd2;
    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = BYTE_IDX_W'(FRAME_BYTES - 1);

    back_state_t             state_reg;
    back_state_t             state_next;
    cmd_t                    cmd_reg;
    cmd_t                    cmd_next;
    logic [1:0]              lk_reg;
    logic [1:0]              lk_next;
    logic signed [Z_W-1:0]   z_reg;
    logic signed [Z_W-1:0]   z_next;
    logic [SIG_IDX_W-1:0]    idx_reg;
    logic [SIG_IDX_W-1:0]    idx_next;
    logic [SIG_W-1:0]        sig_reg;
    logic [SIG_W-1:0]        sig_next;
    logic [SIG_W-1:0]        acc_reg;
    logic [SIG_W-1:0]        acc_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [DUTY_W-1:0]       duty_reg;
    logic [DUTY_W-1:0]       duty_next;
    logic [BYTE_IDX_W-1:0]   cnt_reg;
    logic [BYTE_IDX_W-1:0]   cnt_next;
    logic                    led_valid_reg;
    logic                    led_valid_next;
    led_t                    led_reg;
    led_t                    led_next;

    logic signed [X_W-1:0]    sig_x;
    logic signed [Z_W:0]      z_off;
    logic [IDXP_W-1:0]        idx_prod;
    logic [IDXP_W-1:0]        idx_hi;
    logic [SIG_IDX_W-1:0]     idx_calc;
    logic signed [SPAN_W-1:0] span;
    logic signed [DSUM_W-1:0] duty_sum;
    logic [DSUM_W-17:0]       duty_hi;
    logic [DUTY_W-1:0]        duty_calc;
    logic [HALF_IDX_W-1:0]    half_idx;
    logic signed [DIFF_W-1:0] top_s;
    logic signed [DIFF_W-1:0] bar_diff;
    logic signed [DIFF_W-1:0] mrk_diff;
    logic [7:0]               bar_byte;
    logic [7:0]               mrk_byte;
    logic [7:0]               byte_val;
    logic                     slot_free;

    assign led_valid = led_valid_reg;
    assign led       = led_reg;
    assign slot_free = !led_valid_reg || led_ready;

    // Sigmoid argument for the current lookup
    always_comb
    begin
        case (lk_reg)
            LK_FIRST: sig_x = $signed({1'b0, cmd_reg.day_frac});
            LK_MID:   sig_x = $signed({1'b0, cmd_reg.sunset_frac})
                            - $signed({1'b0, cmd_reg.day_frac});
            default:  sig_x = $signed({1'b0, cmd_reg.day_frac}) - $signed(X_W'(Q16_ONE));
        endcase
    end

    // Nearest table entry, clamped to the table
    assign z_off    = (Z_W + 1)'(z_reg) + $signed((Z_W + 1)'(ZHALF));
    assign idx_prod = IDXP_W'(z_off[Z_W-1:0]) * IDXP_W'(SIGMOID_ENTRIES) + IDXP_W'(ZHALF);
    assign idx_hi   = idx_prod >> ZIDX_SHIFT;
    always_comb
    begin
        if (z_off < 0)
            idx_calc = '0;
        else if (idx_hi > IDXP_W'(SIGMOID_ENTRIES - 1))
            idx_calc = SIG_IDX_W'(SIGMOID_ENTRIES - 1);
        else
            idx_calc = idx_hi[SIG_IDX_W-1:0];
    end

    // Duty blend: min + (full - min) * S, rounded
    assign span     = $signed({1'b0, cfg.full_duty}) - $signed({1'b0, cfg.min_duty});
    assign duty_sum = $signed(DSUM_W'({cfg.min_duty, 16'h0000})) + DSUM_W'(prod_reg)
                    + $signed(DSUM_W'(1 << (Q16_SHIFT - 1)));
    assign duty_hi  = duty_sum[DSUM_W-1:Q16_SHIFT];
    always_comb
    begin
        if (duty_sum < 0)
            duty_calc = '0;
        else if (duty_hi > (DSUM_W - 16)'(1023))
            duty_calc = '1;
        else
            duty_calc = duty_hi[DUTY_W-1:0];
    end

    // Byte content for the current frame position
    assign half_idx = (cnt_reg < BYTE_IDX_W'(HALF_BYTES)) ? cnt_reg[HALF_IDX_W-1:0]
                    : HALF_IDX_W'(cnt_reg - BYTE_IDX_W'(HALF_BYTES));
    assign top_s    = $signed(DIFF_W'(LED_COUNT)) - $signed(DIFF_W'({half_idx, 3'b000}));
    assign bar_diff = top_s - $signed(DIFF_W'(cmd_reg.day_pos));
    assign mrk_diff = top_s - $signed(DIFF_W'(cmd_reg.sunset_pos));

    always_comb
    begin
        if (bar_diff <= 0)
            bar_byte = 8'hFF;
        else if (bar_diff > $signed(DIFF_W'(8)))
            bar_byte = 8'h00;
        else
            bar_byte = 8'hFF << bar_diff[3:0];

        if (cmd_reg.kind == CMD_NORMAL && mrk_diff >= 0 && mrk_diff <= $signed(DIFF_W'(7)))
            mrk_byte = 8'h01 << mrk_diff[2:0];
        else
            mrk_byte = 8'h00;

        if (cmd_reg.kind == CMD_LOST)
            byte_val = (cnt_reg == BYTE_IDX_W'(LOST_MARK_IDX) ||
                        cnt_reg == BYTE_IDX_W'(LOST_BAR_IDX)) ? 8'h01 : 8'h00;
        else if (cnt_reg < BYTE_IDX_W'(HALF_BYTES))
            byte_val = mrk_byte;
        else
            byte_val = bar_byte;
    end

    // Sequencer: on sunset days three table lookups and blend, then one byte per free output slot
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        lk_next        = lk_reg;
        z_next         = z_reg;
        idx_next       = idx_reg;
        sig_next       = sig_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        duty_next      = duty_reg;
        cnt_next       = cnt_reg;
        led_valid_next = led_valid_reg && !led_ready;
        led_next       = led_reg;
        pop            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    cnt_next = '0;
                    lk_next  = LK_FIRST;
                    case (head.kind)
                        CMD_NORMAL:
                        begin
                            state_next = ST_MUL;
                        end
                        CMD_NOSUN:
                        begin
                            duty_next  = head.sun_up ? cfg.full_duty : cfg.min_duty;
                            state_next = ST_SEND;
                        end
                        default:
                        begin
                            duty_next  = cfg.min_duty;
                            state_next = ST_SEND;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                z_next     = Z_W'(sig_x * $signed({1'b0, cfg.tau_inverse}));
                state_next = ST_IDX;
            end
            ST_IDX:
            begin
                idx_next   = idx_calc;
                state_next = ST_ROM;
            end
            ST_ROM:
            begin
                sig_next   = SIG_ROM[idx_reg];
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                case (lk_reg)
                    LK_FIRST: acc_next = sig_reg;
                    LK_MID:   acc_next = (sig_reg < acc_reg) ? sig_reg : acc_reg;
                    default:  acc_next = (sig_reg > acc_reg) ? sig_reg : acc_reg;
                endcase
                if (lk_reg == LK_LAST)
                    state_next = ST_MIX;
                else
                begin
                    lk_next    = lk_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MIX:
            begin
                prod_next  = PROD_W'(span * $signed({1'b0, acc_reg}));
                state_next = ST_DUTY;
            end
            ST_DUTY:
            begin
                duty_next  = duty_calc;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (slot_free)
                begin
                    led_valid_next      = 1'b1;
                    led_next.led_byte   = byte_val;
                    led_next.byte_index = cnt_reg;
                    led_next.last       = (cnt_reg == LAST_BYTE);
                    led_next.duty       = duty_reg;
                    cnt_next            = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_BYTE)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lk_reg        <= LK_FIRST;
            cnt_reg       <= '0;
            led_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lk_reg        <= lk_next;
            cnt_reg       <= cnt_next;
            led_valid_reg <= led_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        z_reg    <= z_next;
        idx_reg  <= idx_next;
        sig_reg  <= sig_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        duty_reg <= duty_next;
        led_reg  <= led_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("frame builder state not one-hot");

    // Inside a frame the next byte follows at once with the next index
    a_byte_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (led_valid && led_ready && !led.last) |=>
        (led_valid && led.byte_index == $past(led.byte_index) + 5'd1))
        else $error("frame bytes out of sequence");

    // One duty value for the whole frame
    a_duty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (led_valid && led_ready && !led.last) |=> (led.duty == $past(led.duty)))
        else $error("duty changed inside a frame");

endmodule

### sim/day_bar_led_frame_and_dimming_core_tb.sv
// Self-checking testbench for the day bar LED frame and dimming core.
module day_bar_led_frame_and_dimming_core_tb
    import dbfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_FRAC      = 131071;
    localparam int Q16           = 65536;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              rpt_valid = 1'b0;
    logic              rpt_ready;
    rpt_t              rpt = '0;
    logic              led_valid;
    logic              led_ready = 1'b0;
    led_t              led;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Register shadow and frame tracking state
    logic [DUTY_W-1:0]  cfg_min = MIN_DUTY_RST;
    logic [DUTY_W-1:0]  cfg_full = FULL_DUTY_RST;
    logic [LIMIT_W-1:0] cfg_limit = LOSS_LIM_RST;
    logic [TAU_W-1:0]   cfg_tau = TAU_INV_RST;
    int                 miss_run = 0;
    bit                 fix_gone = 1'b1;

    int   logistic_rom [SIGMOID_ENTRIES];
    led_t frame_bytes_due [$];
    int   mismatch_count = 0;
    int   quiet_cycles = 0;
    bit   rpt_gaps_on = 1'b1;
    bit   led_stalls_on = 1'b1;

    day_bar_led_frame_and_dimming_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt       (rpt),
        .led_valid (led_valid),
        .led_ready (led_ready),
        .led       (led),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100)
            $display("%0t ERROR %s", $time, what);
        mismatch_count++;
    endtask

    // e^-f in Q30 for a Q16 fraction, 13-term truncated series
    function automatic longint exp_series_q30(input longint f);
        longint term;
        longint acc;
        term = 64'sd1 << 30;
        acc  = term;
        for (int k = 1; k <= 13; k++)
        begin
            term = (term * f) / (longint'(k) * Q16);
            if ((k % 2) != 0)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return (acc < 0) ? 64'sd0 : acc;
    endfunction

    // Logistic table over -8..+8
    task automatic build_logistic_rom();
        longint z;
        longint mag;
        longint e_one;
        longint ex;
        longint den;
        longint v;
        e_one = exp_series_q30(Q16);
        for (int i = 0; i < SIGMOID_ENTRIES; i++)
        begin
            z   = (longint'(i) * 16 * Q16) / SIGMOID_ENTRIES - 8 * Q16;
            mag = (z < 0) ? -z : z;
            ex  = exp_series_q30(mag % Q16);
            for (longint k = 0; k < (mag >>> 16); k++)
                ex = (ex * e_one) >>> 30;
            den = (64'sd1 << 30) + ex;
            if (z >= 0)
                v = ((64'sd1 << 46) + den / 2) / den;
            else
                v = (ex * Q16 + den / 2) / den;
            logistic_rom[i] = (v > 65535) ? 65535 : int'(v);
        end
    endtask

    function automatic longint logistic_at(input longint z);
        longint u;
        longint idx;
        u = z + 8 * Q16;
        if (u < 0)
            return logistic_rom[0];
        idx = (u * SIGMOID_ENTRIES + 8 * Q16) / (16 * Q16);
        if (idx > SIGMOID_ENTRIES - 1)
            idx = SIGMOID_ENTRIES - 1;
        return logistic_rom[idx];
    endfunction

    // Work out the frame bytes that one accepted report produces
    task automatic predict_frame(input rpt_t r);
        logic [7:0] frame [FRAME_BYTES];
        longint     df;
        longint     sf;
        longint     dpos;
        longint     spos;
        longint     top;
        longint     tau;
        longint     l1;
        longint     l2;
        longint     l3;
        longint     blend;
        longint     level;
        led_t       e;
        for (int k = 0; k < FRAME_BYTES; k++)
            frame[k] = 8'h00;
        if (!r.fix_ok)
        begin
            if (miss_run < 255)
                miss_run++;
            if (miss_run >= int'(cfg_limit))
                fix_gone = 1'b1;
            if (!fix_gone)
                return;
            frame[LOST_MARK_IDX] = 8'h01;
            frame[LOST_BAR_IDX]  = 8'h01;
            level = longint'(cfg_min);
        end
        else
        begin
            fix_gone = 1'b0;
            miss_run = 0;
            df   = longint'(r.day_frac);
            sf   = longint'(r.sunset_frac);
            dpos = (LED_COUNT * df + 32768) >>> 16;
            spos = (LED_COUNT * sf + 32768) >>> 16;
            if (r.no_sunset)
                level = r.sun_up ? longint'(cfg_full) : longint'(cfg_min);
            else
            begin
                tau   = longint'(cfg_tau);
                l1    = logistic_at(df * tau);
                l2    = logistic_at((sf - df) * tau);
                l3    = logistic_at((df - Q16) * tau);
                blend = (l1 < l2) ? l1 : l2;
                if (l3 > blend)
                    blend = l3;
                // single sunset marker, byte boundary falls into the next byte
                for (int b = 0; b < HALF_BYTES; b++)
                begin
                    top = LED_COUNT - 8 * b;
                    if (spos > top - 8 && spos <= top)
                        frame[b] = 8'd1 << (top - spos);
                end
                level = (longint'(cfg_min) * Q16
                         + (longint'(cfg_full) - longint'(cfg_min)) * blend + 32768) >>> 16;
            end
            if (level < 0)
                level = 0;
            if (level > 1023)
                level = 1023;
            // thermometer bar
            for (int b = 0; b < HALF_BYTES; b++)
            begin
                top = LED_COUNT - 8 * b;
                if (dpos >= top)
                    frame[HALF_BYTES + b] = 8'hFF;
                else if (dpos < top - 8)
                    frame[HALF_BYTES + b] = 8'h00;
                else
                    frame[HALF_BYTES + b] = 8'hFF << (top - dpos);
            end
        end
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            e.led_byte   = frame[k];
            e.byte_index = BYTE_IDX_W'(k);
            e.last       = (k == FRAME_BYTES - 1);
            e.duty       = DUTY_W'(level);
            frame_bytes_due.push_back(e);
        end
    endtask

    // Frame byte checker and sink-side stalls
    always @(posedge clk)
    begin : led_check
        led_t want;
        if (rst_n && led_valid && led_ready)
        begin
            if (frame_bytes_due.size() == 0)
                report_mismatch($sformatf("unexpected byte %0d idx %0d",
                                          led.led_byte, led.byte_index));
            else
            begin
                want = frame_bytes_due.pop_front();
                if (led.byte_index !== want.byte_index)
                    report_mismatch($sformatf("byte_index %0d, want %0d",
                                              led.byte_index, want.byte_index));
                if (led.led_byte !== want.led_byte)
                    report_mismatch($sformatf("led_byte idx %0d: %h, want %h",
                                              want.byte_index, led.led_byte, want.led_byte));
                if (led.last !== want.last)
                    report_mismatch($sformatf("last idx %0d: %b, want %b",
                                              want.byte_index, led.last, want.last));
                if (led.duty !== want.duty)
                    report_mismatch($sformatf("duty idx %0d: %0d, want %0d",
                                              want.byte_index, led.duty, want.duty));
            end
        end
        led_ready <= led_stalls_on ? ($urandom_range(0, 99) >= 29) : 1'b1;
    end

    // Watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if ((rpt_valid && rpt_ready) || (led_valid && led_ready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("day_bar_led_frame_and_dimming_core_tb: done, errors");
            $finish;
        end
    end

    // One request on the report channel, with random gaps before it
    task automatic send_report(input rpt_t r);
        while (rpt_gaps_on && $urandom_range(0, 99) < 29)
        begin
            rpt_valid <= 1'b0;
            @(posedge clk);
        end
        rpt_valid <= 1'b1;
        rpt       <= r;
        @(posedge clk);
        while (!rpt_ready)
            @(posedge clk);
        predict_frame(r);
    endtask

    task automatic apb_access(input bit wr, input logic [1:0] idx,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [1:0] idx);
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] want;
        case (idx)
            REG_MIN_DUTY:  want = DATA_W'(cfg_min);
            REG_FULL_DUTY: want = DATA_W'(cfg_full);
            REG_LOSS_LIM:  want = DATA_W'(cfg_limit);
            default:       want = DATA_W'(cfg_tau);
        endcase
        apb_access(1'b0, idx, '0, rd);
        if (rd !== want)
            report_mismatch($sformatf("register %0d reads %0d, want %0d", idx, rd, want));
    endtask

    task automatic set_reg(input logic [1:0] idx, input int value);
        logic [DATA_W-1:0] rd;
        apb_access(1'b1, idx, DATA_W'(value), rd);
        case (idx)
            REG_MIN_DUTY:  cfg_min = DUTY_W'(value);
            REG_FULL_DUTY: cfg_full = DUTY_W'(value);
            REG_LOSS_LIM:  cfg_limit = LIMIT_W'(value);
            default:       cfg_tau = TAU_W'(value);
        endcase
        check_reg(idx);
    endtask

    // Wait for all frames, then let any frameless report settle
    task automatic wait_frames_done();
        rpt_valid <= 1'b0;
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic rpt_t report_of(input bit fix, input int day, input int sun,
                                       input bit nosun, input bit up);
        rpt_t r;
        r.fix_ok      = fix;
        r.day_frac    = FRAC_W'(day);
        r.sunset_frac = FRAC_W'(sun);
        r.no_sunset   = nosun;
        r.sun_up      = up;
        return r;
    endfunction

    function automatic int rand_frac();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom_range(0, MAX_FRAC);
        if (pick == 1)
            return ($urandom_range(0, 1) != 0) ? Q16 : 0;
        return $urandom_range(0, Q16);
    endfunction

    // Random report; sunset often close to the day position to hit the dimming slope
    function automatic rpt_t random_report(input int fix_pct);
        int day;
        int sun;
        day = rand_frac();
        if ($urandom_range(0, 1) != 0)
            sun = rand_frac();
        else
            sun = day + int'($urandom_range(0, 16384)) - 8192;
        if (sun < 0)
            sun = 0;
        if (sun > MAX_FRAC)
            sun = MAX_FRAC;
        return report_of($urandom_range(0, 99) < fix_pct, day, sun,
                         $urandom_range(0, 99) < 15, $urandom_range(0, 1) != 0);
    endfunction

    task automatic test_reset_values();
        check_reg(REG_MIN_DUTY);
        check_reg(REG_FULL_DUTY);
        check_reg(REG_LOSS_LIM);
        check_reg(REG_TAU_INV);
    endtask

    // Fix is lost right after reset: misses still give the midpoint frame
    task automatic test_lost_at_boot();
        send_report(report_of(1'b0, 0, 0, 1'b0, 1'b0));
        send_report(report_of(1'b0, MAX_FRAC, MAX_FRAC, 1'b1, 1'b1));
        wait_frames_done();
    endtask

    // Field extremes, marker byte boundaries, no-sunset days
    task automatic test_directed_frames();
        int marks [7] = '{1, 8, 9, 56, 104, 111, 112};
        int frac;
        send_report(report_of(1'b1, 0, 0, 1'b0, 1'b0));
        send_report(report_of(1'b1, Q16, Q16, 1'b0, 1'b1));
        send_report(report_of(1'b1, MAX_FRAC, MAX_FRAC, 1'b0, 1'b0));
        send_report(report_of(1'b1, 0, MAX_FRAC, 1'b0, 1'b1));
        foreach (marks[i])
        begin
            frac = (marks[i] * Q16) / LED_COUNT + 1;
            send_report(report_of(1'b1, frac, frac, 1'b0, 1'b1));
        end
        send_report(report_of(1'b1, 32768, 50000, 1'b1, 1'b0));
        send_report(report_of(1'b1, 32768, 50000, 1'b1, 1'b1));
        wait_frames_done();
    endtask

    // Missed reports counted up to the loss limit, and a zero limit
    task automatic test_loss_limit();
        set_reg(REG_LOSS_LIM, 3);
        send_report(report_of(1'b1, 20000, 45000, 1'b0, 1'b1));
        repeat (4) send_report(report_of(1'b0, 20000, 45000, 1'b0, 1'b1));
        send_report(report_of(1'b1, 21000, 45000, 1'b0, 1'b1));
        wait_frames_done();
        set_reg(REG_LOSS_LIM, 0);
        send_report(report_of(1'b1, 30000, 45000, 1'b0, 1'b1));
        send_report(report_of(1'b0, 30000, 45000, 1'b0, 1'b1));
        wait_frames_done();
    endtask

    // A high loss limit keeps a run of misses frameless
    task automatic test_high_limit();
        set_reg(REG_LOSS_LIM, 255);
        send_report(report_of(1'b1, 40000, 45000, 1'b0, 1'b1));
        repeat (20) send_report(random_report(0));
        wait_frames_done();
    endtask

    // Random reports over several register settings, extremes included
    task automatic test_random_settings();
        int mins   [5] = '{0, 1023, 512, 100, 0};
        int fulls  [5] = '{1023, 1, 512, 1000, 0};
        int limits [5] = '{1, 255, 2, 30, 0};
        int taus   [5] = '{1, 255, 0, 72, 0};
        int n;
        for (int p = 0; p < 5; p++)
        begin
            if (p == 4)
            begin
                mins[p]   = $urandom_range(0, 1023);
                fulls[p]  = $urandom_range(1, 1023);
                limits[p] = $urandom_range(1, 8);
                taus[p]   = $urandom_range(1, 255);
            end
            set_reg(REG_MIN_DUTY, mins[p]);
            set_reg(REG_FULL_DUTY, fulls[p]);
            set_reg(REG_LOSS_LIM, limits[p]);
            set_reg(REG_TAU_INV, taus[p]);
            n = 0;
            while (n < 27)
            begin
                // now and then a run of misses to reach the lost state
                if ($urandom_range(0, 99) < 6)
                    repeat ($urandom_range(1, 12)) send_report(random_report(0));
                send_report(random_report(85));
                n++;
            end
            wait_frames_done();
        end
    endtask

    // Back-to-back traffic with no gaps or stalls on either side
    task automatic test_back_to_back();
        set_reg(REG_LOSS_LIM, 4);
        set_reg(REG_TAU_INV, 72);
        rpt_gaps_on   = 1'b0;
        led_stalls_on = 1'b0;
        repeat (40) send_report(random_report(80));
        wait_frames_done();
        rpt_gaps_on   = 1'b1;
        led_stalls_on = 1'b1;
    endtask

    initial
    begin
        build_logistic_rom();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_lost_at_boot();
        test_directed_frames();
        test_loss_limit();
        test_high_limit();
        test_random_settings();
        test_back_to_back();
        wait_frames_done();
        if (mismatch_count == 0)
            $display("day_bar_led_frame_and_dimming_core_tb: done, clean");
        else
            $display("day_bar_led_frame_and_dimming_core_tb: done, errors");
        $finish;
    end

endmodule

### files.f
hw/rtl/dbfd_pkg.sv
hw/rtl/dbfd_front.sv
hw/rtl/dbfd_cmd_fifo.sv
hw/rtl/dbfd_back.sv
hw/rtl/day_bar_led_frame_and_dimming_core.sv
sim/day_bar_led_frame_and_dimming_core_tb.sv
